// File: hw/rtl/dfp_pkg.sv
// Shared constants and the result descriptor type of the field projector.
`default_nettype none

package dfp_pkg;

    // Byte codes
    localparam logic [7:0] SEP_CHAR = 8'h23;
    localparam logic [7:0] EOL_CHAR = 8'h0A;

    // Width of the field select mask
    localparam int SEL_BITS = 7;

    // Number of selectable fields is at most SEL_BITS, so at most 14 '#' per request
    localparam int SEL_CNT_W = 3;
    localparam int HASH_W    = SEL_CNT_W + 1;

    // What one request produces: a run of '#' bytes, then an optional tail byte
    typedef struct packed {
        logic [HASH_W-1:0] hash_cnt;
        logic              tail_v;
        logic [7:0]        tail_byte;
    } dfp_desc_t;

endpackage

`default_nettype wire

// File: hw/rtl/dfp_in_if.sv
// Input byte channel: valid/ready handshake carrying one record byte.
`default_nettype none

interface dfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dfp_out_if.sv
// Output byte channel: valid/ready handshake carrying a projected byte and last flag.
`default_nettype none

interface dfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/delimited_field_projector.sv
// Top level of the delimited field projector: field tracking, pending stage and byte emitter.
//
// Usage:
//   in_ch  carries one record byte per request ('#' separates fields, newline ends a record).
//   out_ch carries projected bytes; last marks the final byte caused by one input request.
//   cfg_we/cfg_wdata write the 7-bit field select mask (reset value selects field 0 only).
// Path: an accepted request is registered in the pending stage, then in the emitter.
// Throughput: one input request per cycle while each request yields at most one byte
//   and out_ch.ready is high. A request yielding N bytes holds the output until all N are
//   sent (2 for a selected separator, up to 15 for a newline), as the output port is single.
//   Requests that yield nothing (unselected bytes, absorbed '##') are dropped at accept.
// Stall: one extra request is taken into the pending stage while the output waits;
//   after that in_ch.ready stays low until the emitter finishes its current request.
// Reset: field index, byte count and separator flag clear, the mask returns to 1,
//   and both the pending stage and the emitter empty.
`default_nettype none

module delimited_field_projector #(
    parameter int NUM_FIELDS      = 7,
    parameter int MAX_FIELD_CHARS = 100
) (
    input  wire                          clk,
    input  wire                          rst_n,
    dfp_in_if.sink                       in_ch,
    dfp_out_if.source                    out_ch,
    input  wire                          cfg_we,
    input  wire [dfp_pkg::SEL_BITS-1:0]  cfg_wdata
);
    import dfp_pkg::*;

    localparam int FW = $clog2(NUM_FIELDS + 1);
    localparam int CW = $clog2(MAX_FIELD_CHARS + 1);

    logic [SEL_BITS-1:0] field_select_reg;
    logic [FW-1:0]       field_idx_reg, field_idx_next;
    logic [CW-1:0]       char_cnt_reg, char_cnt_next;
    logic                after_sep_reg, after_sep_next;

    dfp_desc_t pend_reg;
    logic      pend_v_reg;
    dfp_desc_t emit_reg;
    logic      emit_v_reg;

    dfp_desc_t      new_desc;
    logic           new_has_out;
    logic           cur_sel;
    logic [SEL_CNT_W-1:0] rem_cnt;
    logic           in_fire;
    logic           out_fire;
    logic           emit_last;
    logic           emit_done;
    logic           pend_move;

    // Hold the field select mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_select_reg <= SEL_BITS'(1);
        end
        else if (cfg_we)
        begin
            field_select_reg <= cfg_wdata;
        end
    end

    // Look up whether the current field is selected, and count selected fields still ahead
    always_comb
    begin
        cur_sel = 1'b0;
        rem_cnt = '0;
        for (int i = 0; i < SEL_BITS; i++)
        begin
            if (i < NUM_FIELDS)
            begin
                if (field_select_reg[i] && (field_idx_reg == FW'(i)))
                begin
                    cur_sel = 1'b1;
                end
                if (field_select_reg[i] && (FW'(i) >= field_idx_reg))
                begin
                    rem_cnt = rem_cnt + SEL_CNT_W'(1);
                end
            end
        end
    end

    // Decide the output of one byte and advance the field state
    always_comb
    begin
        new_desc       = '0;
        field_idx_next = field_idx_reg;
        char_cnt_next  = char_cnt_reg;
        after_sep_next = after_sep_reg;
        if (in_ch.char_in == EOL_CHAR)
        begin
            new_desc.hash_cnt  = {rem_cnt, 1'b0};
            new_desc.tail_v    = 1'b1;
            new_desc.tail_byte = EOL_CHAR;
            field_idx_next     = '0;
            char_cnt_next      = '0;
            after_sep_next     = 1'b0;
        end
        else if (in_ch.char_in == SEP_CHAR)
        begin
            if (after_sep_reg)
            begin
                after_sep_next = 1'b0;
            end
            else
            begin
                if (cur_sel)
                begin
                    new_desc.hash_cnt = HASH_W'(2);
                end
                if (field_idx_reg < FW'(NUM_FIELDS))
                begin
                    field_idx_next = field_idx_reg + FW'(1);
                end
                char_cnt_next  = '0;
                after_sep_next = 1'b1;
            end
        end
        else
        begin
            after_sep_next = 1'b0;
            if (cur_sel && (char_cnt_reg < CW'(MAX_FIELD_CHARS)))
            begin
                new_desc.tail_v    = 1'b1;
                new_desc.tail_byte = in_ch.char_in;
                char_cnt_next      = char_cnt_reg + CW'(1);
            end
        end
    end

    assign new_has_out = (new_desc.hash_cnt != '0) || new_desc.tail_v;

    // Handshake control
    assign emit_last  = (emit_reg.hash_cnt == '0) ||
                        ((emit_reg.hash_cnt == HASH_W'(1)) && !emit_reg.tail_v);
    assign out_fire   = emit_v_reg && out_ch.ready;
    assign emit_done  = out_fire && emit_last;
    assign pend_move  = pend_v_reg && (!emit_v_reg || emit_done);
    assign in_ch.ready = !pend_v_reg || pend_move;
    assign in_fire    = in_ch.valid && in_ch.ready;

    // Advance field state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_idx_reg <= '0;
            char_cnt_reg  <= '0;
            after_sep_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            field_idx_reg <= field_idx_next;
            char_cnt_reg  <= char_cnt_next;
            after_sep_reg <= after_sep_next;
        end
    end

    // Hold one pending request; drop requests that produce nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            pend_v_reg <= new_has_out;
        end
        else if (pend_move)
        begin
            pend_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_reg <= new_desc;
        end
    end

    // Emit bytes: the '#' run first, then the tail byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_v_reg <= 1'b0;
        end
        else if (pend_move)
        begin
            emit_v_reg <= 1'b1;
        end
        else if (emit_done)
        begin
            emit_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            emit_reg <= pend_reg;
        end
        else if (out_fire && !emit_last)
        begin
            emit_reg.hash_cnt <= emit_reg.hash_cnt - HASH_W'(1);
        end
    end

    assign out_ch.valid    = emit_v_reg;
    assign out_ch.out_byte = (emit_reg.hash_cnt != '0) ? SEP_CHAR : emit_reg.tail_byte;
    assign out_ch.last     = emit_last;

`ifndef SYNTHESIS
    // An emitting request always has at least one byte to give
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_v_reg |-> ((emit_reg.hash_cnt != '0) || emit_reg.tail_v))
        else $error("emitter holds an empty request");

    // Field index saturates at the field count
    assert property (@(posedge clk) disable iff (!rst_n)
        field_idx_reg <= FW'(NUM_FIELDS))
        else $error("field index past field count");

    // Copied byte count never passes the truncation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        char_cnt_reg <= CW'(MAX_FIELD_CHARS))
        else $error("field byte count past limit");

    // A pending request reaches an idle emitter in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_v_reg && !emit_v_reg) |=> emit_v_reg)
        else $error("pending request not moved to idle emitter");
`endif

endmodule

`default_nettype wire

// File: verif/delimited_field_projector_checker.sv
`timescale 1ns / 1ps
// Checker for the field projector: predicts projected bytes per request and compares results.

module delimited_field_projector_checker #(
    parameter int NUM_FIELDS      = 7,
    parameter int MAX_FIELD_CHARS = 100
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dfp_in_if                            in_ch,
    dfp_out_if                           out_ch,
    input  logic                         cfg_we,
    input  logic [dfp_pkg::SEL_BITS-1:0] cfg_wdata,
    output int                           fail_count,
    output int                           pending
);
    import dfp_pkg::*;

    localparam int IDX_W = $clog2(NUM_FIELDS + 1);
    localparam int CNT_W = $clog2(MAX_FIELD_CHARS + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } proj_byte_t;

    // Bytes still owed by the block, oldest first
    proj_byte_t          projected_q[$];

    // Shadow of the block's mask and record position
    logic [SEL_BITS-1:0] select_mask;
    logic [IDX_W-1:0]    field_idx;
    logic [CNT_W-1:0]    copied;
    logic                sep_seen;

    function automatic logic field_on(input int idx);
        if (idx >= NUM_FIELDS || idx >= SEL_BITS)
            return 1'b0;
        return select_mask[idx];
    endfunction

    // Advance the record position by one byte and queue the bytes it produces
    task automatic project_char(input logic [7:0] c);
        logic [7:0] burst[$];
        int         f;
        int         k;
        if (c == EOL_CHAR)
        begin
            // close every selected field not yet closed, then end the line
            for (f = int'(field_idx); f < NUM_FIELDS; f++)
            begin
                if (field_on(f))
                begin
                    burst.push_back(SEP_CHAR);
                    burst.push_back(SEP_CHAR);
                end
            end
            burst.push_back(EOL_CHAR);
            field_idx = '0;
            copied    = '0;
            sep_seen  = 1'b0;
        end
        else if (c == SEP_CHAR)
        begin
            // a second '#' right after a field end is swallowed
            if (sep_seen)
                sep_seen = 1'b0;
            else
            begin
                if (field_on(int'(field_idx)))
                begin
                    burst.push_back(SEP_CHAR);
                    burst.push_back(SEP_CHAR);
                end
                if (int'(field_idx) < NUM_FIELDS)
                    field_idx = field_idx + 1'b1;
                copied   = '0;
                sep_seen = 1'b1;
            end
        end
        else
        begin
            // copy up to the field limit, drop the rest
            sep_seen = 1'b0;
            if (field_on(int'(field_idx)) && int'(copied) < MAX_FIELD_CHARS)
            begin
                burst.push_back(c);
                copied = copied + 1'b1;
            end
        end
        for (k = 0; k < burst.size(); k++)
            projected_q.push_back('{data: burst[k], last: (k == burst.size() - 1)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        proj_byte_t want;
        if (!rst_n)
        begin
            projected_q.delete();
            select_mask = SEL_BITS'(1);
            field_idx   = '0;
            copied      = '0;
            sep_seen    = 1'b0;
            pending     = 0;
        end
        else
        begin
            // compare each accepted result with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (projected_q.size() == 0)
                begin
                    $error("unexpected result: out_byte 8'h%02h last %0b",
                           out_ch.out_byte, out_ch.last);
                    fail_count++;
                end
                else
                begin
                    want = projected_q.pop_front();
                    if (out_ch.out_byte !== want.data)
                    begin
                        $error("out_byte mismatch: expected 8'h%02h, actual 8'h%02h",
                               want.data, out_ch.out_byte);
                        fail_count++;
                    end
                    if (out_ch.last !== want.last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               want.last, out_ch.last);
                        fail_count++;
                    end
                end
            end
            // track mask writes
            if (cfg_we)
                select_mask = cfg_wdata;
            // predict the accepted request
            if (in_ch.valid && in_ch.ready)
                project_char(in_ch.char_in);
            pending = projected_q.size();
        end
    end

endmodule

// File: verif/delimited_field_projector_tb.sv
`timescale 1ns / 1ps
// Testbench top for the field projector: clock, reset, record stimulus, idling and verdict.

module delimited_field_projector_tb;
    import dfp_pkg::*;

    localparam int MAX_FIELD_CHARS = 100;
    localparam int RANDOM_ITEMS    = 370;
    localparam int PHASE_ITEMS     = 60;
    localparam int HOLD_AT         = 120;
    localparam int LONG_HOLD       = 90;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_taken = 1'b0;
    logic                quiet    = 1'b0;
    logic                cfg_we;
    logic [SEL_BITS-1:0] cfg_wdata;
    int                  sent        = 0;
    int                  hold_reqs   = 0;
    int                  long_budget = 0;
    int                  fail_count;
    int                  pending;

    dfp_in_if  in_ch ();
    dfp_out_if out_ch ();

    delimited_field_projector u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    delimited_field_projector_checker u_proj_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // Register the input handshake so the driver can see it at the falling edge
    always @(posedge clk)
    begin
        in_taken <= in_ch.valid && in_ch.ready;
    end

    // Offer one request, with an occasional idle burst first, and hold it until taken
    task automatic push_char(input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= b;
        @(negedge clk);
        while (!in_taken)
            @(negedge clk);
        sent++;
    endtask

    task automatic push_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == SEP_CHAR || b == EOL_CHAR);
        return b;
    endfunction

    task automatic push_text(input int len);
        int i;
        for (i = 0; i < len; i++)
            push_char(text_byte());
    endtask

    // Well-formed record: mixed separators, short fields, rare overlong ones
    task automatic push_record();
        int nfields;
        int f;
        int k;
        int len;
        nfields = $urandom_range(1, 10);
        for (f = 0; f < nfields; f++)
        begin
            if (f > 0)
            begin
                k = $urandom_range(0, 9);
                push_char(SEP_CHAR);
                if (k >= 7)
                    push_char(SEP_CHAR);
                if (k == 9)
                    push_char(SEP_CHAR);
            end
            if (long_budget > 0 && $urandom_range(0, 39) == 0)
            begin
                len = $urandom_range(MAX_FIELD_CHARS - 2, MAX_FIELD_CHARS + 4);
                long_budget--;
            end
            else
                len = $urandom_range(0, 5);
            push_text(len);
        end
        if ($urandom_range(0, 4) == 0)
            push_char(SEP_CHAR);
        push_char(EOL_CHAR);
    endtask

    // Loose byte soup, heavy on delimiters
    task automatic push_noise();
        int n;
        int i;
        int r;
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                push_char(SEP_CHAR);
            else if (r == 3)
                push_char(EOL_CHAR);
            else
                push_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Stop offering and wait for every predicted byte plus pipeline slack
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_select(input logic [SEL_BITS-1:0] mask);
        cfg_we    <= 1'b1;
        cfg_wdata <= mask;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Output side: random stall bursts, one long hold-off on request
    initial
    begin
        int idle_left;
        int holds_done;
        idle_left    = 0;
        holds_done   = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_reqs)
            begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            else if (idle_left > 0)
            begin
                out_ch.ready <= 1'b0;
                idle_left--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ch.ready <= 1'b0;
                idle_left = $urandom_range(0, 6);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Bound the run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("delimited_field_projector_tb: done, errors");
        $finish;
    end

    initial
    begin
        int                  start_sent;
        int                  phase_start;
        int                  phase;
        logic                hold_sent;
        logic [SEL_BITS-1:0] mask;
        in_ch.valid   = 1'b0;
        in_ch.char_in = 8'h00;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        hold_sent     = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset mask projects field 0 only
        push_string("ab#c\n");
        drain();

        // All fields on: bare newline closes all seven, then extreme bytes and '#' runs
        write_select(7'h7F);
        push_char(EOL_CHAR);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(SEP_CHAR);
        push_char(SEP_CHAR);
        push_char(SEP_CHAR);
        push_char(EOL_CHAR);
        drain();

        // Nothing selected: only the newline comes through
        write_select(7'h00);
        push_string("q#\n");
        drain();

        // Random part: one overlong field first, then phases with a new mask each
        write_select(7'h7F);
        start_sent = sent;
        push_text(MAX_FIELD_CHARS + 3);
        push_char(SEP_CHAR);
        push_string("xy\n");
        long_budget = 1;
        phase       = 0;
        phase_start = sent;
        while (sent - start_sent < RANDOM_ITEMS)
        begin
            if (sent - phase_start >= PHASE_ITEMS)
            begin
                drain();
                phase++;
                case (phase)
                    1:       mask = 7'h00;
                    2:       mask = 7'h40;
                    3:       mask = 7'h01;
                    default: mask = SEL_BITS'($urandom_range(0, 127));
                endcase
                write_select(mask);
                phase_start = sent;
            end
            if (!hold_sent && sent - start_sent >= HOLD_AT)
            begin
                hold_reqs++;
                hold_sent = 1'b1;
            end
            if (sent - start_sent >= RANDOM_ITEMS * 4 / 5)
                quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                push_noise();
            else
                push_record();
        end
        drain();

        if (fail_count == 0)
            $display("delimited_field_projector_tb: done, clean");
        else
            $display("delimited_field_projector_tb: done, errors");
        $finish;
    end

endmodule
